>>> sv/dlsp_pkg.sv
// Shared types and constants for the dual linked stack pool.
package dlsp_pkg;

   localparam int POOL_DEPTH_DEFAULT = 256;
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      FUNC_PUSH    = 2'd0,
      FUNC_POP     = 2'd1,
      FUNC_MOVE_MA = 2'd2,
      FUNC_MOVE_AM = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_LINK  = 2'd1,
      ST_VALUE = 2'd2,
      ST_RESP  = 2'd3
   } state_type;

endpackage

>>> sv/dual_linked_stack_pool.sv
// Two linked stacks sharing one node pool, run by a small sequencer.
//
// One request carries an operation code and a push value: push onto main,
// pop main, move the main top to aux, or move the aux top to main. Each
// request gives exactly one response with a status, both stack sizes,
// both top values and both empty flags.
// A request is taken only while req_stall is low, which is in the idle
// state; the block then works on that request alone. The node link is read
// from the link memory in the cycle after acceptance; pops and moves then
// read the value of the newly exposed node from the value memory.
// The response follows the link state for a push or a rejected request,
// and the link and value states for a successful pop or move. While rsp_stall
// is high the response holds unchanged; the cycle after it is taken the
// block is idle again, so no new request is taken until the last response
// is; the extra value state comes from the value read that depends on the
// registered link read.
// Synchronous reset empties both stacks and the free list and marks every
// node as unused; the node memories themselves are not cleared.
module dual_linked_stack_pool
   import dlsp_pkg::*;
#(
   parameter int POOL_DEPTH = POOL_DEPTH_DEFAULT,
   localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1,
   localparam int CNT_W = $clog2(POOL_DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_func,
   input  logic signed [DATA_W-1:0] req_push_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [CNT_W-1:0]         rsp_main_size,
   output logic [CNT_W-1:0]         rsp_aux_size,
   output logic signed [DATA_W-1:0] rsp_main_top,
   output logic signed [DATA_W-1:0] rsp_aux_top,
   output logic                     rsp_main_empty,
   output logic                     rsp_aux_empty
);

   state_type          state_ff, state_in;
   func_type           func_ff, func_in;
   logic [DATA_W-1:0]  value_ff, value_in;
   status_type         status_ff, status_in;
   logic [CNT_W-1:0]   fresh_mark_ff, fresh_mark_in;
   logic [IDX_W-1:0]   free_head_ff, free_head_in;
   logic [CNT_W-1:0]   free_size_ff, free_size_in;
   logic [IDX_W-1:0]   main_head_ff, main_head_in;
   logic [IDX_W-1:0]   aux_head_ff, aux_head_in;
   logic [CNT_W-1:0]   main_count_ff, main_count_in;
   logic [CNT_W-1:0]   aux_count_ff, aux_count_in;
   logic [DATA_W-1:0]  main_top_ff, main_top_in;
   logic [DATA_W-1:0]  aux_top_ff, aux_top_in;

   logic [IDX_W-1:0]   link_mem [POOL_DEPTH];
   logic [DATA_W-1:0]  value_mem [POOL_DEPTH];
   logic [IDX_W-1:0]   link_rd_ff;
   logic [DATA_W-1:0]  value_rd_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   wr_addr;
   logic [IDX_W-1:0]   link_wdata;
   logic               link_we;
   logic               value_we;
   logic               req_take;

   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[wr_addr] <= link_wdata;
      end
      if (value_we) begin
         value_mem[wr_addr] <= value_ff;
      end
      link_rd_ff  <= link_mem[rd_addr];
      value_rd_ff <= value_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fresh_mark_ff <= '0;
         free_head_ff  <= '0;
         free_size_ff  <= '0;
         main_head_ff  <= '0;
         aux_head_ff   <= '0;
         main_count_ff <= '0;
         aux_count_ff  <= '0;
         main_top_ff   <= '0;
         aux_top_ff    <= '0;
         status_ff     <= STATUS_DONE;
      end else begin
         state_ff      <= state_in;
         fresh_mark_ff <= fresh_mark_in;
         free_head_ff  <= free_head_in;
         free_size_ff  <= free_size_in;
         main_head_ff  <= main_head_in;
         aux_head_ff   <= aux_head_in;
         main_count_ff <= main_count_in;
         aux_count_ff  <= aux_count_in;
         main_top_ff   <= main_top_in;
         aux_top_ff    <= aux_top_in;
         status_ff     <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      value_ff <= value_in;
   end

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      fresh_mark_in = fresh_mark_ff;
      free_head_in  = free_head_ff;
      free_size_in  = free_size_ff;
      main_head_in  = main_head_ff;
      aux_head_in   = aux_head_ff;
      main_count_in = main_count_ff;
      aux_count_in  = aux_count_ff;
      main_top_in   = main_top_ff;
      aux_top_in    = aux_top_ff;
      rd_addr       = link_rd_ff;
      wr_addr       = main_head_ff;
      link_wdata    = free_head_ff;
      link_we       = 1'b0;
      value_we      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            unique case (func_type'(req_func))
               FUNC_PUSH:    rd_addr = free_head_ff;
               FUNC_POP:     rd_addr = main_head_ff;
               FUNC_MOVE_MA: rd_addr = main_head_ff;
               FUNC_MOVE_AM: rd_addr = aux_head_ff;
            endcase
            if (req_take) begin
               func_in  = func_type'(req_func);
               value_in = req_push_value;
               state_in = ST_LINK;
            end
         end

         ST_LINK: begin
            status_in = STATUS_DONE;
            state_in  = ST_VALUE;
            unique case (func_ff)
               FUNC_PUSH: begin
                  state_in = ST_RESP;
                  if (free_size_ff != '0) begin
                     wr_addr      = free_head_ff;
                     free_head_in = link_rd_ff;
                     free_size_in = free_size_ff - CNT_W'(1);
                  end else begin
                     wr_addr       = fresh_mark_ff[IDX_W-1:0];
                     fresh_mark_in = fresh_mark_ff + CNT_W'(1);
                  end
                  if (free_size_ff != '0 || fresh_mark_ff != CNT_W'(POOL_DEPTH)) begin
                     link_wdata    = main_head_ff;
                     link_we       = 1'b1;
                     value_we      = 1'b1;
                     main_head_in  = wr_addr;
                     main_count_in = main_count_ff + CNT_W'(1);
                     main_top_in   = value_ff;
                  end else begin
                     fresh_mark_in = fresh_mark_ff;
                     status_in     = STATUS_FULL;
                  end
               end
               FUNC_POP: begin
                  if (main_count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     state_in  = ST_RESP;
                  end else begin
                     wr_addr       = main_head_ff;
                     link_wdata    = free_head_ff;
                     link_we       = 1'b1;
                     free_head_in  = main_head_ff;
                     free_size_in  = free_size_ff + CNT_W'(1);
                     main_head_in  = link_rd_ff;
                     main_count_in = main_count_ff - CNT_W'(1);
                  end
               end
               FUNC_MOVE_MA: begin
                  if (main_count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     state_in  = ST_RESP;
                  end else begin
                     wr_addr       = main_head_ff;
                     link_wdata    = aux_head_ff;
                     link_we       = 1'b1;
                     aux_head_in   = main_head_ff;
                     aux_count_in  = aux_count_ff + CNT_W'(1);
                     aux_top_in    = main_top_ff;
                     main_head_in  = link_rd_ff;
                     main_count_in = main_count_ff - CNT_W'(1);
                  end
               end
               FUNC_MOVE_AM: begin
                  if (aux_count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     state_in  = ST_RESP;
                  end else begin
                     wr_addr       = aux_head_ff;
                     link_wdata    = main_head_ff;
                     link_we       = 1'b1;
                     main_head_in  = aux_head_ff;
                     main_count_in = main_count_ff + CNT_W'(1);
                     main_top_in   = aux_top_ff;
                     aux_head_in   = link_rd_ff;
                     aux_count_in  = aux_count_ff - CNT_W'(1);
                  end
               end
            endcase
         end

         ST_VALUE: begin
            if (func_ff == FUNC_MOVE_AM) begin
               aux_top_in = value_rd_ff;
            end else begin
               main_top_in = value_rd_ff;
            end
            state_in = ST_RESP;
         end

         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   assign rsp_valid      = (state_ff == ST_RESP);
   assign rsp_status     = status_ff;
   assign rsp_main_size  = main_count_ff;
   assign rsp_aux_size   = aux_count_ff;
   assign rsp_main_empty = (main_count_ff == '0);
   assign rsp_aux_empty  = (aux_count_ff == '0);
   assign rsp_main_top   = rsp_main_empty ? '0 : main_top_ff;
   assign rsp_aux_top    = rsp_aux_empty ? '0 : aux_top_ff;

endmodule

>>> sv/dlsp_checker.sv
// Port-level checks for the dual linked stack pool, bound to the top level.
module dlsp_checker
   import dlsp_pkg::*;
#(
   parameter int POOL_DEPTH = POOL_DEPTH_DEFAULT,
   localparam int CNT_W = $clog2(POOL_DEPTH + 1)
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [CNT_W-1:0]         rsp_main_size,
   input logic [CNT_W-1:0]         rsp_aux_size,
   input logic signed [DATA_W-1:0] rsp_main_top,
   input logic                     rsp_main_empty
);

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("Block took a request while the previous one was in flight.");

   a_no_request_during_response: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("Request port open while a response is pending.");

   a_stalled_response_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_main_size)
         && $stable(rsp_aux_size))
      else $error("Stalled response changed.");

   a_empty_top_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_main_empty |-> rsp_main_top == '0 && rsp_main_size == '0)
      else $error("Empty main stack reported a size or top value.");

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_main_size} + {1'b0, rsp_aux_size})
         <= (CNT_W + 1)'(POOL_DEPTH))
      else $error("Stacks hold more nodes than the pool.");

endmodule

bind dual_linked_stack_pool dlsp_checker #(.POOL_DEPTH(POOL_DEPTH)) u_dlsp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_main_size  (rsp_main_size),
   .rsp_aux_size   (rsp_aux_size),
   .rsp_main_top   (rsp_main_top),
   .rsp_main_empty (rsp_main_empty)
);
